/* rtl/core/imh_pkg.sv */
// Package for the indexed max-heap core: action, status and back-part state
// codes, sizes, front-to-back request type. No dependencies.
`timescale 1ns / 1ps
package imh_pkg;
  localparam int unsigned HeapSizeDef = 1023;
  localparam int unsigned KeyBitsDef  = 32;
  localparam int unsigned IdW         = 10;
  localparam int unsigned InKeyW      = 32;
  localparam int unsigned StatW       = 2;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_BUILD   = 2'd1,
    ACT_CHANGE  = 2'd2,
    ACT_EXTRACT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BAD_ID = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_LOAD_WR,
    BK_SINK_RD,
    BK_SINK_CMP,
    BK_SINK_SWP,
    BK_SWIM_RD,
    BK_SWIM_CMP,
    BK_EXT_TOP,
    BK_EXT_LAST,
    BK_EXT_WR,
    BK_BUILD_NEXT,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    action_e            action;
    logic [IdW-1:0]     item_id;
    logic [InKeyW-1:0]  key;
    logic               id_ok;
  } req_t;
endpackage

/* rtl/core/indexed_max_heap_core.sv */
// Top level of the indexed max-heap: a request front with a two-entry queue
// and a heap engine back part. Depends on imh_pkg, imh_front, imh_back.
//
//   channel | direction | fields                               | handshake
//   in      | input     | action, item_id, key                 | in_valid_i / in_ready_o
//   out     | output    | status, top_key, top_id, live_count  | out_valid_o / out_ready_i
//
// The queue registers each request before the engine takes it. Each sink
// level does up to three reads on the single slot port, a compare and two
// writes; each swim level does two reads, a compare and, if it moves, two
// writes. Extract reads the root and the last entry and writes both before
// sinking from the root; build sinks every live slot from the last to the root.
// After reset a clearing pass writes HEAP_SIZE+1 slots, one per cycle; the
// queue still takes up to two requests meanwhile. A stalled result sits in
// the result register; the engine runs the next request and waits at its end.
`timescale 1ns / 1ps
module indexed_max_heap_core #(
  parameter int unsigned HEAP_SIZE = imh_pkg::HeapSizeDef,
  parameter int unsigned KEY_BITS  = imh_pkg::KeyBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [imh_pkg::IdW-1:0]     item_id_i,
  input  logic [imh_pkg::InKeyW-1:0]  key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [imh_pkg::InKeyW-1:0]  top_key_o,
  output logic [imh_pkg::IdW-1:0]     top_id_o,
  output logic [imh_pkg::IdW-1:0]     live_count_o
);
  // slot index width follows the heap size
  localparam int unsigned SlotW = $clog2(HEAP_SIZE + 1);

  logic          req_valid, req_ready, clearing;
  imh_pkg::req_t req;

  imh_front #(.HEAP_SIZE(HEAP_SIZE), .SLOT_W(SlotW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .item_id_i, .key_i,
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  imh_back #(.HEAP_SIZE(HEAP_SIZE), .KEY_BITS(KEY_BITS), .SLOT_W(SlotW)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_ready_o(req_ready),
    .req_i(req), .out_valid_o, .out_ready_i, .status_o, .top_key_o,
    .top_id_o, .live_count_o, .clearing_o(clearing)
  );

`ifndef SYNTH
  // no request may enter the engine during the clearing pass
  a_no_req_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !req_ready) else $error("request taken while clearing");
  // a held result must not change under backpressure
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(top_key_o)
    && $stable(top_id_o) && $stable(live_count_o))
    else $error("result changed while stalled");
  // an error result reports no removed item
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != imh_pkg::ST_OK |-> top_id_o == '0)
    else $error("error result carries an id");
`endif
endmodule

/* rtl/core/imh_front.sv */
// Front part: accepts requests, checks the id range and queues them.
// Depends on imh_pkg.
`timescale 1ns / 1ps
module imh_front #(
  parameter int unsigned HEAP_SIZE = imh_pkg::HeapSizeDef,
  parameter int unsigned SLOT_W    = imh_pkg::IdW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [imh_pkg::IdW-1:0]     item_id_i,
  input  logic [imh_pkg::InKeyW-1:0]  key_i,
  output logic                        req_valid_o,
  input  logic                        req_ready_i,
  output imh_pkg::req_t               req_o
);
  // two-entry queue
  imh_pkg::req_t q_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  imh_pkg::req_t nr;
  logic          push, pop;

  always_comb begin
    nr.action  = imh_pkg::action_e'(action_i);
    nr.item_id = item_id_i;
    nr.key     = key_i;
    nr.id_ok   = (item_id_i != '0) &&
                 ({{(SLOT_W+1){1'b0}}, item_id_i} <= (SLOT_W+imh_pkg::IdW+1)'(HEAP_SIZE));
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_valid_o && req_ready_i;
  assign req_o       = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= nr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/core/imh_back.sv */
// Back part: executes heap actions over the key and map memories and holds
// the result register. Depends on imh_pkg.
`timescale 1ns / 1ps
module imh_back #(
  parameter int unsigned HEAP_SIZE = imh_pkg::HeapSizeDef,
  parameter int unsigned KEY_BITS  = imh_pkg::KeyBitsDef,
  parameter int unsigned SLOT_W    = imh_pkg::IdW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  imh_pkg::req_t               req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [imh_pkg::InKeyW-1:0]  top_key_o,
  output logic [imh_pkg::IdW-1:0]     top_id_o,
  output logic [imh_pkg::IdW-1:0]     live_count_o,
  output logic                        clearing_o
);
  localparam int unsigned AW = SLOT_W;
  localparam int unsigned Depth = HEAP_SIZE + 1;
  localparam int unsigned IW = imh_pkg::InKeyW;
  // keys held in offset form: MSB inverted so unsigned compare is signed order
  localparam logic [KEY_BITS-1:0] SentSigned = (KEY_BITS >= 18) ?
      KEY_BITS'(-64'sd99999) : {1'b1, {(KEY_BITS-1){1'b0}}};
  localparam logic [KEY_BITS-1:0] Sent = SentSigned ^ {1'b1, {(KEY_BITS-1){1'b0}}};

  // memories: key and id per slot (one array, keeps swaps to 2 writes),
  // slot per id
  logic [KEY_BITS+AW-1:0] ent_mem [Depth];
  logic [AW-1:0]          pos_mem [Depth];

  // single port per memory in each cycle: read A/B alternating via addr mux
  logic [AW-1:0]          ea_addr, pa_addr;
  logic [KEY_BITS+AW-1:0] ea_rd;
  logic [AW-1:0]          pa_rd;
  logic                   ea_we, pa_we;
  logic [AW-1:0]          ea_waddr, pa_waddr;
  logic [KEY_BITS+AW-1:0] ea_wd;
  logic [AW-1:0]          pa_wd;

  always_ff @(posedge clk_i) begin
    if (ea_we) ent_mem[ea_waddr] <= ea_wd;
    ea_rd <= ent_mem[ea_addr];
  end
  always_ff @(posedge clk_i) begin
    if (pa_we) pos_mem[pa_waddr] <= pa_wd;
    pa_rd <= pos_mem[pa_addr];
  end

  imh_pkg::back_state_e st_q, st_d;
  imh_pkg::req_t        req_q, req_d;
  logic [AW:0]   live_q, live_d;
  logic [AW:0]   cur_q, cur_d;      // slot being moved
  logic [AW:0]   bld_q, bld_d;      // build cursor
  logic [AW:0]   best_q, best_d;
  logic [1:0]    rd_q, rd_d;        // read phase within sink/swim
  logic [KEY_BITS+AW-1:0] e_cur_q, e_cur_d, e_l_q, e_l_d, e_r_q, e_r_d;
  logic [AW:0]   clr_q;
  logic          clr_busy_q;
  logic          ov_q, ov_d;
  // working result of the request in progress
  logic [1:0]    wst_q, wst_d;
  logic [IW-1:0] wkey_q, wkey_d;
  logic [imh_pkg::IdW-1:0] wid_q, wid_d;
  // result register, held while the result waits
  logic [1:0]    ost_q, ost_d;
  logic [IW-1:0] okey_q, okey_d;
  logic [imh_pkg::IdW-1:0] oid_q, oid_d;
  logic [imh_pkg::IdW-1:0] olive_q, olive_d;
  logic          swim_after_q, swim_after_d;

  function automatic logic [KEY_BITS-1:0] to_key(input logic [IW-1:0] k);
    logic [KEY_BITS-1:0] v;
    v = KEY_BITS'($signed(k));
    return v ^ {1'b1, {(KEY_BITS-1){1'b0}}};
  endfunction

  function automatic logic [IW-1:0] from_key(input logic [KEY_BITS-1:0] k);
    logic [KEY_BITS-1:0] v;
    v = k ^ {1'b1, {(KEY_BITS-1){1'b0}}};
    return IW'($signed(v));
  endfunction

  logic [AW+1:0] lch, rch;
  assign lch = {cur_q, 1'b0};
  assign rch = {cur_q, 1'b1};

  assign clearing_o   = clr_busy_q;
  assign req_ready_o  = (st_q == imh_pkg::BK_IDLE) && !clr_busy_q;
  assign out_valid_o  = ov_q;
  assign status_o     = ost_q;
  assign top_key_o    = okey_q;
  assign top_id_o     = oid_q;
  assign live_count_o = olive_q;

  always_comb begin
    st_d = st_q; req_d = req_q; live_d = live_q; cur_d = cur_q; bld_d = bld_q;
    best_d = best_q; rd_d = rd_q; e_cur_d = e_cur_q; e_l_d = e_l_q; e_r_d = e_r_q;
    ov_d = ov_q; ost_d = ost_q; okey_d = okey_q; oid_d = oid_q; olive_d = olive_q;
    wst_d = wst_q; wkey_d = wkey_q; wid_d = wid_q;
    swim_after_d = swim_after_q;
    ea_addr = cur_q[AW-1:0]; pa_addr = req_q.item_id[AW-1:0];
    ea_we = 1'b0; ea_waddr = '0; ea_wd = '0;
    pa_we = 1'b0; pa_waddr = '0; pa_wd = '0;
    if (clr_busy_q) begin
      ea_we = 1'b1; ea_waddr = clr_q[AW-1:0]; ea_wd = {Sent, clr_q[AW-1:0]};
      pa_we = 1'b1; pa_waddr = clr_q[AW-1:0]; pa_wd = clr_q[AW-1:0];
    end
    if (out_valid_o && out_ready_i) ov_d = 1'b0;
    case (st_q)
      imh_pkg::BK_IDLE: begin
        if (req_valid_i && !clr_busy_q) begin
          req_d = req_i;
          pa_addr = req_i.item_id[AW-1:0];
          wst_d = imh_pkg::ST_OK; wkey_d = '0; wid_d = '0;
          case (req_i.action)
            imh_pkg::ACT_LOAD, imh_pkg::ACT_CHANGE: begin
              if (!req_i.id_ok) begin
                wst_d = imh_pkg::ST_BAD_ID; st_d = imh_pkg::BK_DONE;
              end else st_d = imh_pkg::BK_LOOKUP;
            end
            imh_pkg::ACT_BUILD: begin
              bld_d = live_q; st_d = imh_pkg::BK_BUILD_NEXT;
            end
            default: begin
              if (live_q == '0) begin
                wst_d = imh_pkg::ST_EMPTY; st_d = imh_pkg::BK_DONE;
              end else begin
                cur_d = (AW+1)'(1); st_d = imh_pkg::BK_EXT_TOP;
              end
            end
          endcase
        end
      end
      imh_pkg::BK_LOOKUP: begin
        // pa_rd holds the slot of the id
        cur_d = {1'b0, pa_rd};
        if (req_q.action == imh_pkg::ACT_LOAD) begin
          st_d = imh_pkg::BK_LOAD_WR;
        end else if (pa_rd == '0 || {1'b0, pa_rd} > live_q) begin
          wst_d = imh_pkg::ST_BAD_ID; st_d = imh_pkg::BK_DONE;
        end else begin
          st_d = imh_pkg::BK_LOAD_WR;
        end
        ea_addr = pa_rd;
      end
      imh_pkg::BK_LOAD_WR: begin
        // ea_rd holds the entry at the slot; rewrite its key
        ea_we = 1'b1; ea_waddr = cur_q[AW-1:0];
        ea_wd = {to_key(req_q.key), ea_rd[AW-1:0]};
        if (req_q.action == imh_pkg::ACT_LOAD) st_d = imh_pkg::BK_DONE;
        else begin
          swim_after_d = 1'b1; rd_d = 2'd0; st_d = imh_pkg::BK_SINK_RD;
        end
      end
      imh_pkg::BK_SINK_RD: begin
        // three reads: current, left, right (one per cycle); only current if there is no left child
        case (rd_q)
          2'd0: ea_addr = cur_q[AW-1:0];
          2'd1: begin ea_addr = lch[AW-1:0]; e_cur_d = ea_rd; end
          2'd2: begin ea_addr = rch[AW-1:0]; e_l_d = ea_rd; end
          default: e_r_d = ea_rd;
        endcase
        rd_d = rd_q + 2'd1;
        if (rd_q == 2'd3) st_d = imh_pkg::BK_SINK_CMP;
        if (rd_q == 2'd1 && lch > {1'b0, live_q}) begin
          st_d = imh_pkg::BK_SINK_CMP; e_cur_d = ea_rd;
        end
      end
      imh_pkg::BK_SINK_CMP: begin
        logic [KEY_BITS+AW-1:0] be;
        be = e_cur_q; best_d = cur_q;
        if (lch <= {1'b0, live_q} && be[KEY_BITS+AW-1:AW] < e_l_q[KEY_BITS+AW-1:AW]) begin
          be = e_l_q; best_d = lch[AW:0];
        end
        if (rch <= {1'b0, live_q} && be[KEY_BITS+AW-1:AW] < e_r_q[KEY_BITS+AW-1:AW]) begin
          be = e_r_q; best_d = rch[AW:0];
        end
        e_l_d = be;
        if (best_d == cur_q) begin
          if (swim_after_q) begin
            rd_d = 2'd0; st_d = imh_pkg::BK_SWIM_RD;
          end else st_d = imh_pkg::BK_BUILD_NEXT;
        end else st_d = imh_pkg::BK_SINK_SWP;
      end
      imh_pkg::BK_SINK_SWP: begin
        // swap cur (e_cur_q) and best (e_l_q): first best's entry to cur, then cur's to best, each with its slot map
        case (rd_q)
          2'd0: begin
            ea_we = 1'b1; ea_waddr = cur_q[AW-1:0]; ea_wd = e_l_q;
            pa_we = 1'b1; pa_waddr = e_l_q[AW-1:0]; pa_wd = cur_q[AW-1:0];
            rd_d = 2'd1;
          end
          default: begin
            ea_we = 1'b1; ea_waddr = best_q[AW-1:0]; ea_wd = e_cur_q;
            pa_we = 1'b1; pa_waddr = e_cur_q[AW-1:0]; pa_wd = best_q[AW-1:0];
            cur_d = best_q; rd_d = 2'd0;
            st_d = (st_q == imh_pkg::BK_SINK_SWP && best_q < cur_q) ?
                   imh_pkg::BK_SWIM_RD : imh_pkg::BK_SINK_RD;
          end
        endcase
      end
      imh_pkg::BK_SWIM_RD: begin
        case (rd_q)
          2'd0: ea_addr = cur_q[AW-1:0];
          2'd1: begin ea_addr = cur_q[AW:1]; e_cur_d = ea_rd; end
          default: e_l_d = ea_rd;
        endcase
        rd_d = rd_q + 2'd1;
        if (cur_q <= (AW+1)'(1)) st_d = imh_pkg::BK_DONE;
        else if (rd_q == 2'd2) st_d = imh_pkg::BK_SWIM_CMP;
      end
      imh_pkg::BK_SWIM_CMP: begin
        rd_d = 2'd0;
        if (e_cur_q[KEY_BITS+AW-1:AW] > e_l_q[KEY_BITS+AW-1:AW]) begin
          best_d = {1'b0, cur_q[AW:1]}; st_d = imh_pkg::BK_SINK_SWP;
        end else st_d = imh_pkg::BK_DONE;
      end
      imh_pkg::BK_EXT_TOP: begin
        ea_addr = '0; ea_addr[0] = 1'b1;
        rd_d = 2'd0; st_d = imh_pkg::BK_EXT_LAST;
      end
      imh_pkg::BK_EXT_LAST: begin
        e_cur_d = ea_rd;
        wkey_d = from_key(ea_rd[KEY_BITS+AW-1:AW]);
        wid_d  = imh_pkg::IdW'(ea_rd[AW-1:0]);
        ea_addr = live_q[AW-1:0];
        st_d = imh_pkg::BK_EXT_WR;
      end
      imh_pkg::BK_EXT_WR: begin
        // last entry to root, removed entry (sentinel key) to last slot
        if (rd_q == 2'd0) begin
          e_l_d = ea_rd;
          ea_we = 1'b1; ea_waddr = live_q[AW-1:0];
          ea_wd = {Sent, e_cur_q[AW-1:0]};
          pa_we = 1'b1; pa_waddr = e_cur_q[AW-1:0]; pa_wd = live_q[AW-1:0];
          rd_d = 2'd1;
        end else begin
          ea_we = 1'b1; ea_waddr = (AW)'(1); ea_wd = e_l_q;
          if (live_q == (AW+1)'(1)) ea_wd = {Sent, e_cur_q[AW-1:0]};
          pa_we = 1'b1; pa_waddr = e_l_q[AW-1:0]; pa_wd = (AW)'(1);
          if (live_q == (AW+1)'(1)) pa_we = 1'b0;
          live_d = live_q - (AW+1)'(1);
          cur_d = (AW+1)'(1); rd_d = 2'd0; swim_after_d = 1'b0;
          bld_d = '0; st_d = imh_pkg::BK_SINK_RD;
        end
      end
      imh_pkg::BK_BUILD_NEXT: begin
        if (bld_q == '0) st_d = imh_pkg::BK_DONE;
        else begin
          cur_d = bld_q; bld_d = bld_q - (AW+1)'(1);
          rd_d = 2'd0; swim_after_d = 1'b0; st_d = imh_pkg::BK_SINK_RD;
        end
      end
      imh_pkg::BK_DONE: begin
        // hand the result over once the result register is free
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; st_d = imh_pkg::BK_IDLE;
          ost_d = wst_q; okey_d = wkey_q; oid_d = wid_q;
          olive_d = imh_pkg::IdW'(live_q);
        end
      end
      default: st_d = imh_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= imh_pkg::BK_IDLE;
      live_q <= (AW+1)'(HEAP_SIZE);
      ov_q <= 1'b0;
      clr_q <= '0;
      clr_busy_q <= 1'b1;
      rd_q <= 2'd0;
      swim_after_q <= 1'b0;
    end else begin
      st_q <= st_d; live_q <= live_d; ov_q <= ov_d; rd_q <= rd_d;
      swim_after_q <= swim_after_d;
      if (clr_busy_q) begin
        clr_q <= clr_q + (AW+1)'(1);
        if (clr_q == (AW+1)'(HEAP_SIZE)) clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; cur_q <= cur_d; bld_q <= bld_d; best_q <= best_d;
    e_cur_q <= e_cur_d; e_l_q <= e_l_d; e_r_q <= e_r_d;
    wst_q <= wst_d; wkey_q <= wkey_d; wid_q <= wid_d;
    ost_q <= ost_d; okey_q <= okey_d; oid_q <= oid_d; olive_q <= olive_d;
  end
endmodule

/* test/imh_checker.sv */
// Checker for the indexed max-heap core: watches both channels, predicts
// each result from its own heap model and compares field by field. Uses imh_pkg.
`timescale 1ns / 1ps
module imh_checker (
  input  logic                       clk_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [1:0]                 action_i,
  input  logic [imh_pkg::IdW-1:0]    item_id_i,
  input  logic [imh_pkg::InKeyW-1:0] key_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [1:0]                 status_i,
  input  logic [imh_pkg::InKeyW-1:0] top_key_i,
  input  logic [imh_pkg::IdW-1:0]    top_id_i,
  input  logic [imh_pkg::IdW-1:0]    live_count_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  localparam int unsigned Size   = imh_pkg::HeapSizeDef;
  localparam int unsigned IdW    = imh_pkg::IdW;
  localparam int unsigned InKeyW = imh_pkg::InKeyW;
  localparam logic signed [31:0] Sentinel = -32'sd99999;

  typedef struct packed {
    imh_pkg::status_e  status;
    logic [InKeyW-1:0] top_key;
    logic [IdW-1:0]    top_id;
    logic [IdW-1:0]    live;
  } heap_result_t;

  logic signed [31:0] heap_key[0:Size];
  int unsigned        slot_of_id[0:Size];
  int unsigned        id_at_slot[0:Size];
  int unsigned        live_items = Size;
  heap_result_t       expected_results[$];
  int                 fails = 0;
  int                 pend = 0;

  assign fail_count_o = fails;
  assign pending_o    = pend;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    int unsigned ia, ib;
    logic signed [31:0] k;
    if (a == b) return;
    ia = id_at_slot[a];
    ib = id_at_slot[b];
    slot_of_id[ia] = b;
    slot_of_id[ib] = a;
    id_at_slot[a] = ib;
    id_at_slot[b] = ia;
    k = heap_key[a];
    heap_key[a] = heap_key[b];
    heap_key[b] = k;
  endfunction

  function automatic void sink_slot(int unsigned s);
    int unsigned best, l, r;
    while (s >= 1 && s <= live_items) begin
      best = s;
      l = 2 * s;
      r = l + 1;
      if (l <= live_items && heap_key[best] < heap_key[l]) best = l;
      if (r <= live_items && heap_key[best] < heap_key[r]) best = r;
      if (best == s) break;
      swap_slots(s, best);
      s = best;
    end
  endfunction

  function automatic void swim_slot(int unsigned s);
    while (s > 1 && heap_key[s] > heap_key[s >> 1]) begin
      swap_slots(s, s >> 1);
      s = s >> 1;
    end
  endfunction

  function automatic heap_result_t heap_apply(logic [1:0] act, logic [IdW-1:0] id,
                                              logic [31:0] key);
    heap_result_t res;
    int unsigned s;
    logic id_ok;
    res = '0;
    res.status = imh_pkg::ST_OK;
    id_ok = (id >= 1) && (id <= Size);
    case (imh_pkg::action_e'(act))
      imh_pkg::ACT_LOAD: begin
        if (!id_ok) res.status = imh_pkg::ST_BAD_ID;
        else heap_key[slot_of_id[id]] = key;
      end
      imh_pkg::ACT_BUILD: begin
        for (int i = live_items; i >= 1; i--) sink_slot(i);
      end
      imh_pkg::ACT_CHANGE: begin
        s = id_ok ? slot_of_id[id] : 0;
        if (s == 0 || s > live_items) begin
          res.status = imh_pkg::ST_BAD_ID;
        end else begin
          heap_key[s] = key;
          sink_slot(s);
          swim_slot(slot_of_id[id]);
        end
      end
      default: begin
        if (live_items == 0) begin
          res.status = imh_pkg::ST_EMPTY;
        end else begin
          res.top_key = heap_key[1];
          res.top_id = id_at_slot[1][IdW-1:0];
          heap_key[1] = Sentinel;
          swap_slots(1, live_items);
          live_items--;
          sink_slot(1);
        end
      end
    endcase
    res.live = live_items[IdW-1:0];
    return res;
  endfunction

  initial begin
    for (int i = 0; i <= Size; i++) begin
      heap_key[i] = Sentinel;
      slot_of_id[i] = i;
      id_at_slot[i] = i;
    end
  end

  always @(posedge clk_i) begin
    heap_result_t want, got;
    if (in_valid_i && in_ready_i)
      expected_results.push_back(heap_apply(action_i, item_id_i, key_i));
    if (out_valid_i && out_ready_i) begin
      got.status  = imh_pkg::status_e'(status_i);
      got.top_key = top_key_i;
      got.top_id  = top_id_i;
      got.live    = live_count_i;
      if (expected_results.size() == 0) begin
        $display("%0t: result without request: status %0d key %0d id %0d live %0d",
                 $time, got.status, $signed(got.top_key), got.top_id, got.live);
        fails++;
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          fails++;
        end
        if (got.top_key != want.top_key) begin
          $display("%0t: top_key expected %0d actual %0d", $time,
                   $signed(want.top_key), $signed(got.top_key));
          fails++;
        end
        if (got.top_id != want.top_id) begin
          $display("%0t: top_id expected %0d actual %0d", $time, want.top_id, got.top_id);
          fails++;
        end
        if (got.live != want.live) begin
          $display("%0t: live_count expected %0d actual %0d", $time, want.live, got.live);
          fails++;
        end
      end
    end
    pend = expected_results.size();
  end
endmodule

/* test/tb_indexed_max_heap_core.sv */
// Testbench top for indexed_max_heap_core: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on imh_pkg and imh_checker.
`timescale 1ns / 1ps
module tb_indexed_max_heap_core;
  localparam longint CycleLimit = 4000000;
  localparam int unsigned IdW    = imh_pkg::IdW;
  localparam int unsigned InKeyW = imh_pkg::InKeyW;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = imh_pkg::ACT_LOAD;
  logic [IdW-1:0]    item_id = '0;
  logic [InKeyW-1:0] key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [InKeyW-1:0] top_key;
  logic [IdW-1:0]    top_id;
  logic [IdW-1:0]    live_count;
  int                fail_count, pending;
  logic              quiet = 1'b0;  // no idling on either side while set
  int                stall_left = 0;
  longint            cycles = 0;

  always #4 clk = ~clk;

  indexed_max_heap_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .item_id_i(item_id), .key_i(key),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .top_key_o(top_key), .top_id_o(top_id),
    .live_count_o(live_count)
  );

  imh_checker u_checker (
    .clk_i(clk), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .action_i(action), .item_id_i(item_id), .key_i(key),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .top_key_i(top_key), .top_id_i(top_id),
    .live_count_i(live_count),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("indexed_max_heap_core test failed");
      $finish;
    end
  end

  // Stall the result side: mostly short gaps, a few long ones.
  always @(posedge clk) begin
    int r;
    if (quiet) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 15) stall_left <= $urandom_range(1, 3);
      else if (r < 18) stall_left <= $urandom_range(10, 40);
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mix tiny keys (to force ties) with full-range ones and the extremes.
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'($urandom_range(0, 6)) - 32'd3;
    if (r < 35) return 32'h7FFF_FFFF;
    if (r < 40) return 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 49) == 0) return '0;
    return IdW'($urandom_range(1, imh_pkg::HeapSizeDef));
  endfunction

  // Present one request; keep valid high across back-to-back requests.
  task automatic send_request(imh_pkg::action_e act, logic [IdW-1:0] id,
                              logic [31:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    item_id  <= id;
    key      <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_mixed(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 199);
      if (r < 100) send_request(imh_pkg::ACT_CHANGE, pick_id(), pick_key());
      else if (r < 180) send_request(imh_pkg::ACT_EXTRACT, IdW'($urandom), $urandom);
      else if (r < 199) send_request(imh_pkg::ACT_LOAD, pick_id(), pick_key());
      else send_request(imh_pkg::ACT_BUILD, IdW'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, bad ids, ties, extracted ids.
    quiet <= 1'b1;
    send_request(imh_pkg::ACT_LOAD, 10'd1, 32'h7FFF_FFFF);
    send_request(imh_pkg::ACT_LOAD, 10'd1023, 32'h8000_0000);
    send_request(imh_pkg::ACT_LOAD, 10'd0, 32'hFFFF_FFFF);
    send_request(imh_pkg::ACT_LOAD, 10'd2, 32'd5);
    send_request(imh_pkg::ACT_LOAD, 10'd3, 32'd5);
    send_request(imh_pkg::ACT_BUILD, 10'd0, 32'd0);
    send_request(imh_pkg::ACT_CHANGE, 10'd0, 32'd7);
    send_request(imh_pkg::ACT_CHANGE, 10'd1023, 32'h7FFF_FFFF);
    send_request(imh_pkg::ACT_EXTRACT, 10'h3FF, 32'hFFFF_FFFF);
    send_request(imh_pkg::ACT_CHANGE, 10'd1023, 32'd1);
    send_request(imh_pkg::ACT_LOAD, 10'd1023, 32'd12);
    send_request(imh_pkg::ACT_EXTRACT, 10'd0, 32'd0);
    send_request(imh_pkg::ACT_EXTRACT, 10'd0, 32'd0);
    send_request(imh_pkg::ACT_CHANGE, 10'd3, 32'hFFFF_FFFF);
    send_request(imh_pkg::ACT_CHANGE, 10'd512, 32'd5);
    send_request(imh_pkg::ACT_CHANGE, 10'd513, 32'd5);
    send_request(imh_pkg::ACT_EXTRACT, 10'd0, 32'd0);
    send_request(imh_pkg::ACT_CHANGE, 10'd700, 32'h8000_0000);
    quiet <= 1'b0;

    // Fill keys at random and build, then mixed traffic.
    for (int i = 0; i < 250; i++) send_request(imh_pkg::ACT_LOAD, pick_id(), pick_key());
    send_request(imh_pkg::ACT_BUILD, 10'd0, 32'd0);
    send_mixed(300);
    quiet <= 1'b1;
    send_mixed(100);
    quiet <= 1'b0;

    // Drain the heap past empty, with some changes mixed in.
    for (int i = 0; i < 1000; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(imh_pkg::ACT_CHANGE, pick_id(), pick_key());
      else send_request(imh_pkg::ACT_EXTRACT, IdW'($urandom), $urandom);
    end
    // Empty or nearly empty heap: loads of extracted ids, builds, errors.
    send_request(imh_pkg::ACT_BUILD, 10'd0, 32'd0);
    send_mixed(200);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("indexed_max_heap_core test passed");
    end else begin
      $display("indexed_max_heap_core test failed");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/imh_pkg.sv
rtl/core/imh_front.sv
rtl/core/imh_back.sv
rtl/core/indexed_max_heap_core.sv
test/imh_checker.sv
test/tb_indexed_max_heap_core.sv
